FILE: rtl/core/sfc_pkg.sv
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int unsigned TAIL_WINDOW = 5;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned TOTAL_W     = POS_W + 1;
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned LEN_W       = 10;
  localparam int unsigned MASK_W      = 32;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [POS_W-1:0]   POS_MAX        = 10'd1023;
  localparam logic [TOTAL_W-1:0] MIN_FRAME      = 11'd10;
  localparam logic [POS_W-1:0]   POS_CMD        = 10'd3;
  localparam logic [POS_W-1:0]   POS_LEN        = 10'd4;
  localparam logic [POS_W-1:0]   POS_PAYLOAD    = 10'd5;
  localparam logic [POS_W-1:0]   POS_SUM_START  = 10'd8;
  localparam logic [POS_W-1:0]   HEAD_BYTES     = 10'd3;

  localparam logic [7:0] TAIL_0 = 8'h2D;
  localparam logic [7:0] TAIL_1 = 8'h31;
  localparam logic [7:0] TAIL_2 = 8'h53;

  localparam logic [MASK_W-1:0] MASK_RESET    = 32'h0007_EFFF;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 10'd300;

  localparam logic [CFG_IDX_W-1:0] REG_CMD_MASK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 8'd1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_BAD_FRAMING = 3'd2,
    ST_BAD_SUM     = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_UNSUPPORTED = 3'd5,
    ST_OVERSIZE    = 3'd6
  } status_t;

  typedef struct packed {
    logic [MASK_W-1:0] cmd_mask;
    logic [LEN_W-1:0]  max_len;
  } cfg_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    status_t    frame_status;
  } result_t;

  function automatic logic [7:0] head_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h1D;
      2'd1:    v = 8'h63;
      2'd2:    v = 8'hC0;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/sfc_ifs.sv
`timescale 1ns / 1ps

interface sfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_message;

  modport source (output valid, output rx_byte, output end_of_message, input ready);
  modport sink   (input valid, input rx_byte, input end_of_message, output ready);
endinterface

interface sfc_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] payload_byte;
  logic [7:0] frame_command;
  logic [7:0] frame_length;
  logic [2:0] frame_status;

  modport source (output valid, output item_kind, output payload_byte, output frame_command,
                  output frame_length, output frame_status, input ready);
  modport sink   (input valid, input item_kind, input payload_byte, input frame_command,
                  input frame_length, input frame_status, output ready);
endinterface

interface sfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/sfc_cfg_regs.sv
`timescale 1ns / 1ps

module sfc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]  wr_data,
  output sfc_pkg::cfg_t                   cfg
);
  import sfc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_CMD_MASK: cfg_nxt.cmd_mask = wr_data[MASK_W-1:0];
        REG_MAX_LEN:  cfg_nxt.max_len  = wr_data[LEN_W-1:0];
        default:      cfg_nxt = cfg_r;  // drop writes to unknown registers
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cmd_mask <= MASK_RESET;
      cfg_r.max_len  <= MAX_LEN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/sfc_step.sv
`timescale 1ns / 1ps

module sfc_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_xfer,
  input  logic [7:0]      rx_byte,
  input  logic            end_of_message,
  input  sfc_pkg::cfg_t   cfg,
  output logic            res_valid,
  output sfc_pkg::result_t res
);
  import sfc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [7:0]       win_r [TAIL_WINDOW];
  logic [7:0]       win_nxt [TAIL_WINDOW];
  logic             head_ok_r, head_ok_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       len_r, len_nxt;

  logic [TOTAL_W-1:0] total;
  logic [SUM_W-1:0]   sent_sum;
  logic               framing_ok;
  logic               cmd_ok;
  logic               payload_hit;
  status_t            verdict;

  always_comb begin
    sum_nxt = (pos_r >= POS_SUM_START) ? sum_r + SUM_W'(win_r[TAIL_WINDOW-1]) : sum_r;
    win_nxt[0] = rx_byte;
    for (int i = 1; i < TAIL_WINDOW; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    head_ok_nxt = head_ok_r;
    if (pos_r < HEAD_BYTES && rx_byte != head_byte(pos_r[1:0])) begin
      head_ok_nxt = 1'b0;
    end
    cmd_nxt = (pos_r == POS_CMD) ? rx_byte : cmd_r;
    len_nxt = (pos_r == POS_LEN) ? rx_byte : len_r;
    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  end

  // Verdict looks at the state including the final byte
  always_comb begin
    total      = {1'b0, pos_r} + 1'b1;
    sent_sum   = {win_nxt[4], win_nxt[3]};
    framing_ok = head_ok_nxt && win_nxt[2] == TAIL_0 && win_nxt[1] == TAIL_1 &&
                 win_nxt[0] == TAIL_2;
    cmd_ok     = (cmd_nxt < 8'd32) && cfg.cmd_mask[cmd_nxt[4:0]];
    if (total > {1'b0, cfg.max_len}) begin
      verdict = ST_OVERSIZE;
    end else if (total < MIN_FRAME) begin
      verdict = ST_TOO_SHORT;
    end else if (!framing_ok) begin
      verdict = ST_BAD_FRAMING;
    end else if (sent_sum != sum_nxt) begin
      verdict = ST_BAD_SUM;
    end else if ({3'b000, len_nxt} != total - MIN_FRAME) begin
      verdict = ST_LEN_MISMATCH;
    end else if (!cmd_ok) begin
      verdict = ST_UNSUPPORTED;
    end else begin
      verdict = ST_OK;
    end
  end

  assign payload_hit = (pos_r >= POS_PAYLOAD) &&
                       ({1'b0, pos_r} < {1'b0, POS_PAYLOAD} + {3'b000, len_r});

  always_comb begin
    res_valid = in_xfer && (end_of_message || payload_hit);
    if (end_of_message) begin
      res.item_kind     = KIND_VERDICT;
      res.payload_byte  = 8'h00;
      res.frame_status  = verdict;
    end else begin
      res.item_kind     = KIND_PAYLOAD;
      res.payload_byte  = rx_byte;
      res.frame_status  = ST_OK;
    end
    res.frame_command = cmd_nxt;
    res.frame_length  = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_xfer && end_of_message)) begin
      pos_r     <= '0;
      sum_r     <= '0;
      head_ok_r <= 1'b1;
      cmd_r     <= '0;
      len_r     <= '0;
      for (int i = 0; i < TAIL_WINDOW; i++) begin
        win_r[i] <= '0;
      end
    end else if (in_xfer) begin
      pos_r     <= pos_nxt;
      sum_r     <= sum_nxt;
      head_ok_r <= head_ok_nxt;
      cmd_r     <= cmd_nxt;
      len_r     <= len_nxt;
      for (int i = 0; i < TAIL_WINDOW; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && end_of_message |=> pos_r == '0 && sum_r == '0 && head_ok_r)
    else $error("message state not cleared after final byte");

  a_no_result_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !end_of_message && pos_r < POS_PAYLOAD |-> !res_valid)
    else $error("result produced for a header byte");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !end_of_message && pos_r == POS_MAX |=> pos_r == POS_MAX)
    else $error("byte position wrapped");

endmodule

FILE: rtl/core/sfc_out_fifo.sv
`timescale 1ns / 1ps

module sfc_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  sfc_pkg::result_t  wr_data,
  output logic              can_accept,
  output logic              rd_valid,
  input  logic              rd_ready,
  output sfc_pkg::result_t  rd_data
);
  import sfc_pkg::*;

  result_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       rd_en;

  assign can_accept = (count_r != 2'd2);
  assign rd_valid   = (count_r != 2'd0);
  assign rd_en      = rd_valid && rd_ready;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ~rd_ptr_r : rd_ptr_r;
    case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/core/serial_frame_checker_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                              Transfer
// in_ch     in   rx_byte[8], end_of_message[1]                        valid & ready
// out_ch    out  item_kind, payload_byte, frame_command,              valid & ready
//                frame_length, frame_status[3]
// cfg_ch    in   index[8], data[32]                                   valid & ready
//
// One byte per cycle unless stalled: each accepted byte is evaluated in the cycle it
// arrives, and its result (if any) is written to a two-entry output buffer.
// in_ch.ready drops only while both buffer entries hold results not yet taken.
// cfg_ch.ready is always high; writes to unknown indexes are dropped.
// Reset clears the message state, the buffer and restores the register defaults.
module serial_frame_checker_core (
  input  logic       clk,
  input  logic       rst_n,
  sfc_in_if.sink     in_ch,
  sfc_out_if.source  out_ch,
  sfc_cfg_if.sink    cfg_ch
);
  import sfc_pkg::*;

  cfg_t    cfg;
  logic    in_xfer;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    buf_ready;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = buf_ready;
  assign in_xfer      = in_ch.valid && buf_ready;

  sfc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  sfc_step u_step (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_xfer        (in_xfer),
    .rx_byte        (in_ch.rx_byte),
    .end_of_message (in_ch.end_of_message),
    .cfg            (cfg),
    .res_valid      (res_valid),
    .res            (res)
  );

  sfc_out_fifo u_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (res_valid),
    .wr_data    (res),
    .can_accept (buf_ready),
    .rd_valid   (out_ch.valid),
    .rd_ready   (out_ch.ready),
    .rd_data    (out_data)
  );

  assign out_ch.item_kind     = out_data.item_kind;
  assign out_ch.payload_byte  = out_data.payload_byte;
  assign out_ch.frame_command = out_data.frame_command;
  assign out_ch.frame_length  = out_data.frame_length;
  assign out_ch.frame_status  = out_data.frame_status;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'hFF;
  localparam logic [23:0] FRAME_HEAD = 24'h1D63C0;

  typedef enum {FLAW_NONE, FLAW_HEAD, FLAW_TAIL, FLAW_SUM, FLAW_CUT} flaw_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_item_t;

  logic clk;
  logic rst_n;

  sfc_in_if  in_bus ();
  sfc_out_if out_bus ();
  sfc_cfg_if cfg_bus ();

  serial_frame_checker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Own copy of the checker state and registers
  logic [MASK_W-1:0] cmd_mask_q;
  logic [LEN_W-1:0]  max_len_q;
  logic [POS_W-1:0]  pos_q;
  logic [SUM_W-1:0]  sum_q;
  logic [7:0]        recent_q [TAIL_WINDOW];
  logic              head_ok_q;
  logic [7:0]        cmd_q;
  logic [7:0]        len_q;

  result_t    owed_items [$];
  rx_item_t   tx_bytes [$];
  logic [7:0] msg_buf [$];
  rx_item_t   next_rx;
  result_t    seen_item;
  result_t    due_item;

  int          faults;
  int          tx_gap;
  int          rx_hold;
  int unsigned cycles;
  bit          in_sent;
  bit          long_hold_req;
  bit          tx_steady;
  bit          rx_steady;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_fault(input string what);
    $display("%0t: mismatch: %s", $time, what);
    faults++;
  endtask

  function automatic int pause_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
  endfunction

  task automatic drop_message();
    pos_q = '0;
    sum_q = '0;
    foreach (recent_q[i]) recent_q[i] = '0;
    head_ok_q = 1'b1;
    cmd_q = '0;
    len_q = '0;
  endtask

  task automatic follow_rx_byte(input logic [7:0] b, input logic last);
    logic [POS_W-1:0]   p;
    logic [TOTAL_W-1:0] total;
    int                 head_idx;
    result_t            r;
    p = pos_q;
    head_idx = int'(p);
    // the oldest window byte joins the sum from the command byte on
    if (p >= POS_SUM_START) sum_q = sum_q + {8'h00, recent_q[TAIL_WINDOW-1]};
    for (int i = TAIL_WINDOW - 1; i > 0; i--) recent_q[i] = recent_q[i-1];
    recent_q[0] = b;
    if (p < HEAD_BYTES && b != FRAME_HEAD[8*(2-head_idx) +: 8]) head_ok_q = 1'b0;
    if (p == POS_CMD) cmd_q = b;
    if (p == POS_LEN) len_q = b;
    if (pos_q < POS_MAX) pos_q = pos_q + 1'b1;

    r.item_kind     = KIND_VERDICT;
    r.payload_byte  = '0;
    r.frame_command = cmd_q;
    r.frame_length  = len_q;
    r.frame_status  = ST_OK;
    if (last) begin
      total = {1'b0, p} + 1'b1;
      if (total > {1'b0, max_len_q})
        r.frame_status = ST_OVERSIZE;
      else if (total < MIN_FRAME)
        r.frame_status = ST_TOO_SHORT;
      else if (!head_ok_q || recent_q[2] != TAIL_0 || recent_q[1] != TAIL_1 ||
               recent_q[0] != TAIL_2)
        r.frame_status = ST_BAD_FRAMING;
      else if ({recent_q[4], recent_q[3]} != sum_q)
        r.frame_status = ST_BAD_SUM;
      else if ({3'b000, len_q} != total - MIN_FRAME)
        r.frame_status = ST_LEN_MISMATCH;
      else if (cmd_q >= 8'd32 || !cmd_mask_q[cmd_q[4:0]])
        r.frame_status = ST_UNSUPPORTED;
      owed_items.push_back(r);
      drop_message();
    end else if (p >= POS_PAYLOAD &&
                 {1'b0, p} < {1'b0, POS_PAYLOAD} + {3'b000, len_q}) begin
      r.item_kind    = KIND_PAYLOAD;
      r.payload_byte = b;
      owed_items.push_back(r);
    end
  endtask

  // fill < 0 gives random payload bytes, else every payload byte is fill
  task automatic build_frame(input logic [7:0] cmd, input logic [7:0] decl, input int plen,
                             input flaw_t flaw, input int fill);
    logic [SUM_W-1:0] s;
    logic [7:0]       v;
    int               at;
    int               keep;
    msg_buf.delete();
    for (int i = 0; i < 3; i++) msg_buf.push_back(FRAME_HEAD[8*(2-i) +: 8]);
    msg_buf.push_back(cmd);
    msg_buf.push_back(decl);
    s = {8'h00, cmd} + {8'h00, decl};
    for (int i = 0; i < plen; i++) begin
      v = (fill < 0) ? 8'($urandom) : 8'(fill);
      msg_buf.push_back(v);
      s = s + {8'h00, v};
    end
    msg_buf.push_back(s[15:8]);
    msg_buf.push_back(s[7:0]);
    msg_buf.push_back(TAIL_0);
    msg_buf.push_back(TAIL_1);
    msg_buf.push_back(TAIL_2);
    case (flaw)
      FLAW_HEAD: at = $urandom_range(0, 2);
      FLAW_TAIL: at = msg_buf.size() - 1 - $urandom_range(0, 2);
      FLAW_SUM:  at = msg_buf.size() - 4 - $urandom_range(0, 1);
      default:   at = -1;
    endcase
    if (at >= 0) msg_buf[at] = msg_buf[at] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_CUT) begin
      keep = $urandom_range(1, msg_buf.size() - 1);
      while (msg_buf.size() > keep) void'(msg_buf.pop_back());
    end
  endtask

  task automatic build_noise(input int n, input bit headed);
    msg_buf.delete();
    for (int i = 0; i < n; i++)
      msg_buf.push_back((headed && i < 3) ? FRAME_HEAD[8*(2-i) +: 8] : 8'($urandom));
  endtask

  task automatic queue_message();
    rx_item_t it;
    foreach (msg_buf[i]) begin
      it.data = msg_buf[i];
      it.last = (i == msg_buf.size() - 1);
      tx_bytes.push_back(it);
    end
  endtask

  task automatic random_traffic(input int budget);
    int         sent;
    int         r;
    int         plen;
    logic [7:0] cmd;
    sent = 0;
    while (sent < budget) begin
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
      cmd  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
      r    = $urandom_range(0, 99);
      if (r < 65)
        build_frame(cmd, 8'(plen), plen, FLAW_NONE, -1);
      else if (r < 70)
        build_frame(cmd, 8'(plen), plen, FLAW_HEAD, -1);
      else if (r < 75)
        build_frame(cmd, 8'(plen), plen, FLAW_TAIL, -1);
      else if (r < 80)
        build_frame(cmd, 8'(plen), plen, FLAW_SUM, -1);
      else if (r < 85)
        build_frame(cmd, 8'(plen + $urandom_range(1, 255)), plen, FLAW_NONE, -1);
      else if (r < 90)
        build_frame(cmd, 8'(plen), plen, FLAW_CUT, -1);
      else
        build_noise($urandom_range(1, 24), r >= 95);
      sent += msg_buf.size();
      queue_message();
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == REG_CMD_MASK)
      cmd_mask_q = value;
    else if (idx == REG_MAX_LEN)
      max_len_q = value[LEN_W-1:0];
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // hold until every queued byte went in and every owed result came out
  task automatic settle(input int extra);
    @(posedge clk);
    while (tx_bytes.size() != 0 || in_bus.valid || owed_items.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // sender: one byte per transfer, random gaps between bytes
  always @(negedge clk) begin
    if ($urandom_range(0, 149) == 0) tx_steady = !tx_steady;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_sent) begin
      in_sent = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_bus.valid <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        next_rx = tx_bytes.pop_front();
        in_bus.rx_byte        <= next_rx.data;
        in_bus.end_of_message <= next_rx.last;
        in_bus.valid          <= 1'b1;
        tx_gap = (tx_steady || $urandom_range(0, 1)) ? 0 : pause_len();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if ($urandom_range(0, 149) == 0) rx_steady = !rx_steady;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_bus.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_hold = LONG_HOLD - 1;
      out_bus.ready <= 1'b0;
    end else if (rx_steady || $urandom_range(0, 2) != 0) begin
      out_bus.ready <= 1'b1;
    end else begin
      rx_hold = pause_len() - 1;
      out_bus.ready <= 1'b0;
    end
  end

  // predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      follow_rx_byte(in_bus.rx_byte, in_bus.end_of_message);
      in_sent = 1'b1;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen_item.item_kind     = out_bus.item_kind;
      seen_item.payload_byte  = out_bus.payload_byte;
      seen_item.frame_command = out_bus.frame_command;
      seen_item.frame_length  = out_bus.frame_length;
      seen_item.frame_status  = status_t'(out_bus.frame_status);
      if (owed_items.size() == 0) begin
        note_fault($sformatf("result with nothing owed, kind %0d status %0d",
                             seen_item.item_kind, seen_item.frame_status));
      end else begin
        due_item = owed_items.pop_front();
        if (seen_item.item_kind !== due_item.item_kind)
          note_fault($sformatf("item_kind got %0d want %0d",
                               seen_item.item_kind, due_item.item_kind));
        if (seen_item.payload_byte !== due_item.payload_byte)
          note_fault($sformatf("payload_byte got %02h want %02h",
                               seen_item.payload_byte, due_item.payload_byte));
        if (seen_item.frame_command !== due_item.frame_command)
          note_fault($sformatf("frame_command got %02h want %02h",
                               seen_item.frame_command, due_item.frame_command));
        if (seen_item.frame_length !== due_item.frame_length)
          note_fault($sformatf("frame_length got %0d want %0d",
                               seen_item.frame_length, due_item.frame_length));
        if (seen_item.frame_status !== due_item.frame_status)
          note_fault($sformatf("frame_status got %0d want %0d",
                               seen_item.frame_status, due_item.frame_status));
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    clk   = 1'b0;
    rst_n = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.rx_byte        = '0;
    in_bus.end_of_message = 1'b0;
    out_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = '0;
    cfg_bus.data          = '0;
    faults        = 0;
    tx_gap        = 0;
    rx_hold       = 0;
    in_sent       = 1'b0;
    long_hold_req = 1'b0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    cmd_mask_q    = MASK_RESET;
    max_len_q     = MAX_LEN_RESET;
    drop_message();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // writes to unknown indexes must leave the defaults in place
    write_reg(REG_SPARE, $urandom);
    write_reg(REG_TOP, $urandom);

    build_frame(8'd0, 8'd0, 0, FLAW_NONE, -1);       queue_message();
    build_frame(8'd18, 8'd255, 255, FLAW_NONE, 8'hFF); queue_message();
    build_frame(8'd17, 8'd4, 4, FLAW_NONE, 8'h00);    queue_message();
    build_frame(8'd12, 8'd3, 3, FLAW_NONE, -1);       queue_message();
    build_frame(8'd32, 8'd2, 2, FLAW_NONE, -1);       queue_message();
    build_frame(8'hFF, 8'd1, 1, FLAW_NONE, -1);       queue_message();
    // short messages, ending before and after the command and length bytes
    build_noise(1, 1'b0); queue_message();
    build_noise(3, 1'b1); queue_message();
    build_noise(4, 1'b1); queue_message();
    build_noise(9, 1'b1); queue_message();
    repeat (3) begin
      build_frame(8'd1, 8'd2, 2, FLAW_HEAD, -1); queue_message();
    end
    build_frame(8'd2, 8'd6, 6, FLAW_TAIL, -1); queue_message();
    build_frame(8'd3, 8'd6, 6, FLAW_SUM, -1);  queue_message();
    build_frame(8'd1, 8'd5, 3, FLAW_NONE, -1); queue_message();
    build_frame(8'd2, 8'd0, 4, FLAW_NONE, -1); queue_message();
    // sum wraps past 16 bits
    build_frame(8'd5, 8'd4, 260, FLAW_NONE, 8'hFF); queue_message();
    settle(4);

    write_reg(REG_CMD_MASK, 32'h0000_0000);
    write_reg(REG_MAX_LEN, 32'd1023);
    build_frame(8'd0, 8'd0, 0, FLAW_NONE, -1); queue_message();
    random_traffic(40);
    // position saturates on a very long message
    build_noise(1030, 1'b0); queue_message();
    settle(4);

    write_reg(REG_CMD_MASK, 32'hFFFF_FFFF);
    write_reg(REG_MAX_LEN, 32'd10);
    build_frame(8'd31, 8'd0, 0, FLAW_NONE, -1); queue_message();
    random_traffic(30);
    settle(4);

    write_reg(REG_MAX_LEN, 32'd0);
    random_traffic(20);
    settle(4);
    write_reg(REG_MAX_LEN, 32'd9);
    build_noise(9, 1'b1); queue_message();
    build_frame(8'd0, 8'd0, 0, FLAW_NONE, -1); queue_message();
    random_traffic(20);
    settle(4);

    write_reg(REG_CMD_MASK, $urandom);
    write_reg(REG_MAX_LEN, $urandom_range(10, 1023));
    // payload-heavy frame so the output side backs up during the long hold
    build_frame(8'($urandom_range(0, 31)), 8'd60, 60, FLAW_NONE, -1);
    queue_message();
    @(posedge clk);
    long_hold_req = 1'b1;
    random_traffic(60);
    settle(0);
    random_traffic(30);
    settle(4);

    write_reg(REG_CMD_MASK, MASK_RESET);
    write_reg(REG_MAX_LEN, 32'(MAX_LEN_RESET));
    random_traffic(40);
    settle(20);

    if (faults == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
